// File: sv/tkr_pkg.sv
// tkr_pkg: shared types, codes and the rank compare for the top-k score ranker.
// No dependencies; used by the interfaces, tkr_cell and top_k_score_ranker.
`default_nettype none

package tkr_pkg;

   localparam int unsigned REF_W    = 64;
   localparam int unsigned SCORE_W  = 32;
   localparam int unsigned RANK_W   = 4;
   localparam int unsigned TOTAL_W  = 5;
   localparam int unsigned CSR_W    = 32;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned RESULT_LIMIT = 16;

   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_KEEP_COUNT  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCORE_FLOOR = 1'b1;

   localparam logic [TOTAL_W-1:0] KEEP_COUNT_RESET = 5'd16;
   localparam logic signed [SCORE_W-1:0] SCORE_FLOOR_RESET = 32'sh8000_0000;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   typedef struct packed {
      logic [REF_W-1:0]          entry_ref;
      logic signed [SCORE_W-1:0] entry_score;
   } entry_type;

   typedef struct packed {
      logic               push;
      logic               rotate;
      logic [TOTAL_W-1:0] total;
      entry_type          cand;
   } ctl_type;

   // a outranks b: higher score, lower reference on a tie
   function automatic logic outranks(entry_type a, entry_type b);
      logic res;
      if (a.entry_score != b.entry_score) begin
         res = (a.entry_score > b.entry_score);
      end else begin
         res = (a.entry_ref < b.entry_ref);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// File: sv/tkr_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on tkr_pkg for field widths.
`default_nettype none

interface tkr_req_if;
   logic                               valid;
   logic                               ready;
   logic                               func;
   logic [tkr_pkg::REF_W-1:0]          cand_ref;
   logic signed [tkr_pkg::SCORE_W-1:0] cand_score;

   modport source (output valid, func, cand_ref, cand_score, input ready);
   modport sink   (input valid, func, cand_ref, cand_score, output ready);
endinterface

interface tkr_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [tkr_pkg::REF_W-1:0]          out_ref;
   logic signed [tkr_pkg::SCORE_W-1:0] out_score;
   logic [tkr_pkg::RANK_W-1:0]         out_rank;
   logic                               out_last;
   logic                               out_empty;

   modport source (output valid, out_ref, out_score, out_rank, out_last, out_empty,
                   input ready);
   modport sink   (input valid, out_ref, out_score, out_rank, out_last, out_empty,
                   output ready);
endinterface

`default_nettype wire

// File: sv/tkr_cell.sv
// tkr_cell: one slot of the sorted chain. Inserts or shifts on a push and
// rotates toward the head on a read. Depends on tkr_pkg.
`default_nettype none

module tkr_cell #(
   parameter int unsigned INDEX = 0
) (
   input  wire                      clock,
   input  wire tkr_pkg::ctl_type    ctl,
   input  wire                      prev_ins,
   input  wire tkr_pkg::entry_type  prev_entry,
   input  wire tkr_pkg::entry_type  next_entry,
   input  wire tkr_pkg::entry_type  head_entry,
   output tkr_pkg::entry_type       entry,
   output logic                     ins
);

   localparam logic [tkr_pkg::TOTAL_W-1:0] MY_IDX  = tkr_pkg::TOTAL_W'(INDEX);
   localparam logic [tkr_pkg::TOTAL_W-1:0] MY_NEXT = tkr_pkg::TOTAL_W'(INDEX + 1);

   tkr_pkg::entry_type entry_ff;
   tkr_pkg::entry_type entry_in;

   // slots past the fill level count as beaten, so the first free one takes the candidate
   assign ins = (MY_IDX >= ctl.total) || tkr_pkg::outranks(ctl.cand, entry_ff);

   always_comb begin
      entry_in = entry_ff;
      if (ctl.push && ins) begin
         entry_in = prev_ins ? prev_entry : ctl.cand;
      end else if (ctl.rotate) begin
         // last occupied slot wraps around to the head
         entry_in = (MY_NEXT == ctl.total) ? head_entry : next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

// File: sv/top_k_score_ranker.sv
// Top-k score ranker: a push is accepted in any idle cycle and, if at or above the
// score floor, written into the sorted cell chain at the accepting edge, so pushes can
// run back to back. A read enters the read state at the accepting edge, then loads the
// kept entries (one empty result if none) into the output register one per cycle while
// the sink keeps up; the input reopens the cycle after the last load.
// Sync reset: fill count 0, keep_count 16, score floor minimum; entries not cleared.
`default_nettype none

module top_k_score_ranker #(
   parameter int unsigned CAPACITY = 16
) (
   input  wire                               clock,
   input  wire                               reset,
   tkr_req_if.sink                           req_if,
   tkr_rsp_if.source                         rsp_if,
   input  wire                               csr_we,
   input  wire [tkr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [tkr_pkg::CSR_W-1:0]          csr_wdata
);

   localparam int unsigned NCELL =
      (CAPACITY < tkr_pkg::RESULT_LIMIT) ? CAPACITY : tkr_pkg::RESULT_LIMIT;
   localparam logic [tkr_pkg::TOTAL_W-1:0] NCELL_T = tkr_pkg::TOTAL_W'(NCELL);

   function automatic logic [tkr_pkg::TOTAL_W-1:0] clamp_cap(
      input logic [tkr_pkg::TOTAL_W-1:0] k);
      logic [tkr_pkg::TOTAL_W-1:0] res;
      res = k;
      if (k == '0) begin
         res = tkr_pkg::TOTAL_W'(1);
      end else if (k > NCELL_T) begin
         res = NCELL_T;
      end
      return res;
   endfunction

   logic [tkr_pkg::TOTAL_W-1:0]         keep_count_ff;
   logic signed [tkr_pkg::SCORE_W-1:0]  score_floor_ff;
   logic [tkr_pkg::TOTAL_W-1:0]         total_ff, total_in;
   tkr_pkg::state_type                  state_ff, state_in;
   logic [tkr_pkg::RANK_W-1:0]          cnt_ff, cnt_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [tkr_pkg::REF_W-1:0]           out_ref_ff;
   logic signed [tkr_pkg::SCORE_W-1:0]  out_score_ff;
   logic [tkr_pkg::RANK_W-1:0]          out_rank_ff;
   logic                                out_last_ff;
   logic                                out_empty_ff;

   logic [tkr_pkg::TOTAL_W-1:0]         cap;
   logic [tkr_pkg::TOTAL_W-1:0]         new_cap;
   logic                                req_fire;
   logic                                push_en;
   logic                                load;
   logic                                last_item;
   tkr_pkg::ctl_type                    ctl;
   tkr_pkg::entry_type                  cand;
   tkr_pkg::entry_type                  cells [NCELL];
   logic                                ins   [NCELL];

   assign cap      = clamp_cap(keep_count_ff);
   assign new_cap  = clamp_cap(csr_wdata[tkr_pkg::TOTAL_W-1:0]);
   assign req_fire = req_if.valid && req_if.ready;
   assign push_en  = req_fire && (req_if.func == tkr_pkg::FUNC_PUSH) &&
                     (req_if.cand_score >= score_floor_ff);
   assign req_if.ready = (state_ff == tkr_pkg::ST_IDLE);

   assign cand.entry_ref   = req_if.cand_ref;
   assign cand.entry_score = req_if.cand_score;

   assign ctl.push   = push_en;
   assign ctl.rotate = load && (total_ff != '0);
   assign ctl.total  = total_ff;
   assign ctl.cand   = cand;

   genvar gi;
   generate
      for (gi = 0; gi < NCELL; gi++) begin : g_cell
         tkr_pkg::entry_type prev_e;
         tkr_pkg::entry_type next_e;
         logic               prev_i;
         if (gi == 0) begin : g_first
            assign prev_e = cand;
            assign prev_i = 1'b0;
         end else begin : g_mid
            assign prev_e = cells[gi-1];
            assign prev_i = ins[gi-1];
         end
         if (gi == NCELL - 1) begin : g_tail
            assign next_e = cells[0];
         end else begin : g_body
            assign next_e = cells[gi+1];
         end
         tkr_cell #(.INDEX(gi)) u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .prev_ins   (prev_i),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .head_entry (cells[0]),
            .entry      (cells[gi]),
            .ins        (ins[gi])
         );
      end
   endgenerate

   // read sequencer
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      load      = (state_ff == tkr_pkg::ST_READ) && (!rsp_valid_ff || rsp_if.ready);
      last_item = (total_ff == '0) ||
                  (tkr_pkg::TOTAL_W'(cnt_ff) == total_ff - tkr_pkg::TOTAL_W'(1));
      case (state_ff)
         tkr_pkg::ST_IDLE: begin
            cnt_in = '0;
            if (req_fire && (req_if.func == tkr_pkg::FUNC_READ)) begin
               state_in = tkr_pkg::ST_READ;
            end
         end
         tkr_pkg::ST_READ: begin
            if (load) begin
               cnt_in = cnt_ff + tkr_pkg::RANK_W'(1);
               if (last_item) begin
                  state_in = tkr_pkg::ST_IDLE;
                  cnt_in   = '0;
               end
            end
         end
         default: begin
            state_in = tkr_pkg::ST_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tkr_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // fill level
   always_comb begin
      total_in = total_ff;
      if (csr_we && (csr_index == tkr_pkg::CSR_KEEP_COUNT)) begin
         if (total_ff > new_cap) begin
            total_in = new_cap;
         end
      end else if (push_en && (total_ff < cap)) begin
         total_in = total_ff + tkr_pkg::TOTAL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff       <= '0;
         keep_count_ff  <= tkr_pkg::KEEP_COUNT_RESET;
         score_floor_ff <= tkr_pkg::SCORE_FLOOR_RESET;
      end else begin
         total_ff <= total_in;
         if (csr_we && (csr_index == tkr_pkg::CSR_KEEP_COUNT)) begin
            keep_count_ff <= csr_wdata[tkr_pkg::TOTAL_W-1:0];
         end
         if (csr_we && (csr_index == tkr_pkg::CSR_SCORE_FLOOR)) begin
            score_floor_ff <= tkr_pkg::SCORE_W'(signed'(csr_wdata));
         end
      end
   end

   // output register
   assign rsp_valid_in = load ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         if (total_ff == '0) begin
            out_ref_ff   <= '0;
            out_score_ff <= '0;
            out_rank_ff  <= '0;
            out_last_ff  <= 1'b0;
            out_empty_ff <= 1'b1;
         end else begin
            out_ref_ff   <= cells[0].entry_ref;
            out_score_ff <= cells[0].entry_score;
            out_rank_ff  <= cnt_ff;
            out_last_ff  <= last_item;
            out_empty_ff <= 1'b0;
         end
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.out_ref   = out_ref_ff;
   assign rsp_if.out_score = out_score_ff;
   assign rsp_if.out_rank  = out_rank_ff;
   assign rsp_if.out_last  = out_last_ff;
   assign rsp_if.out_empty = out_empty_ff;

`ifndef SYNTHESIS
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= NCELL_T)
      else $error("fill level above cell count");

   a_total_cap: assert property (@(posedge clock) disable iff (reset)
      !csr_we |-> total_ff <= cap)
      else $error("fill level above keep count");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tkr_pkg::ST_READ) && (total_ff != '0) |->
         tkr_pkg::TOTAL_W'(cnt_ff) < total_ff)
      else $error("read index past fill level");

   a_push_grow: assert property (@(posedge clock) disable iff (reset)
      push_en && (total_ff < cap) && !csr_we |=> total_ff == $past(total_ff) + 5'd1)
      else $error("accepted push into free slot did not grow store");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_empty_ff |-> !out_last_ff && (out_rank_ff == '0))
      else $error("empty result carries rank or last flag");
`endif

endmodule

`default_nettype wire

// File: tb/sv/tb_top_k_score_ranker.sv
// Self-checking testbench for top_k_score_ranker: random and directed pushes and reads,
// checked result by result against a ranked-store predictor kept in this file.
// Depends on tkr_pkg and the tkr_req_if / tkr_rsp_if channel interfaces.
`default_nettype none

module tb_top_k_score_ranker;
   import tkr_pkg::*;

   localparam int STORE_MAX   = 16;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic                      func;
      logic [REF_W-1:0]          cand_ref;
      logic signed [SCORE_W-1:0] cand_score;
   } cand_item_t;

   typedef struct packed {
      logic [REF_W-1:0]          out_ref;
      logic signed [SCORE_W-1:0] out_score;
      logic [RANK_W-1:0]         out_rank;
      logic                      out_last;
      logic                      out_empty;
   } ranked_t;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   tkr_req_if req_ch ();
   tkr_rsp_if rsp_ch ();

   top_k_score_ranker u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predicted store, best entry first
   entry_type                 kept [STORE_MAX];
   int                        kept_n;
   logic [TOTAL_W-1:0]        keep_cfg;
   logic signed [SCORE_W-1:0] floor_cfg;

   cand_item_t req_items[$];
   ranked_t    expected_ranks[$];

   cand_item_t drv_item;
   logic       drv_busy;
   int         drv_gap;
   int         sink_wait;
   logic       calm;
   int         cycles;
   int         n_sent, n_reads, n_checked, n_bad, n_cfg;

   always #6 clock = ~clock;

   // ---------------- predictor ----------------

   // higher score first, lower reference breaks a tie
   function automatic logic signed [95:0] rank_key(entry_type e);
      return $signed({e.entry_score, ~e.entry_ref});
   endfunction

   function automatic int keep_limit(logic [TOTAL_W-1:0] v);
      if (v == 0) return 1;
      if (v > STORE_MAX) return STORE_MAX;
      return int'(v);
   endfunction

   function automatic void cfg_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] d);
      if (idx == CSR_KEEP_COUNT) begin
         keep_cfg = d[TOTAL_W-1:0];
         if (kept_n > keep_limit(keep_cfg)) kept_n = keep_limit(keep_cfg);
      end else if (idx == CSR_SCORE_FLOOR) begin
         floor_cfg = d;
      end
   endfunction

   function automatic void store_push(entry_type c);
      int cap, pos, stop, i;
      cap = keep_limit(keep_cfg);
      if (c.entry_score < floor_cfg) return;
      if (kept_n > cap) kept_n = cap;
      pos = 0;
      while (pos < kept_n && rank_key(c) <= rank_key(kept[pos])) pos++;
      if (kept_n < cap) begin
         stop = kept_n;
         kept_n++;
      end else if (pos < kept_n) begin
         stop = kept_n - 1;
      end else begin
         return;
      end
      for (i = stop; i > pos; i--) kept[i] = kept[i-1];
      kept[pos] = c;
   endfunction

   function automatic void store_read();
      ranked_t r;
      int k;
      if (kept_n == 0) begin
         r = '0;
         r.out_empty = 1'b1;
         expected_ranks.push_back(r);
         return;
      end
      for (k = 0; k < kept_n; k++) begin
         r.out_ref   = kept[k].entry_ref;
         r.out_score = kept[k].entry_score;
         r.out_rank  = RANK_W'(k);
         r.out_last  = (k == kept_n - 1);
         r.out_empty = 1'b0;
         expected_ranks.push_back(r);
      end
   endfunction

   // ---------------- stimulus helpers ----------------

   function automatic void queue_item(logic f, logic [REF_W-1:0] r, logic [SCORE_W-1:0] s);
      cand_item_t it;
      it.func       = f;
      it.cand_ref   = r;
      it.cand_score = s;
      req_items.push_back(it);
   endfunction

   function automatic cand_item_t rand_item();
      cand_item_t it;
      it.func = ($urandom_range(0, 5) == 0) ? FUNC_READ : FUNC_PUSH;
      case ($urandom_range(0, 3))
         0:       it.cand_ref = REF_W'($urandom_range(0, 7));
         1:       it.cand_ref = ~REF_W'($urandom_range(0, 7));
         default: it.cand_ref = {$urandom, $urandom};
      endcase
      case ($urandom_range(0, 4))
         0: it.cand_score = int'($urandom_range(0, 16)) - 8;
         1: it.cand_score = floor_cfg + int'($urandom_range(0, 3)) - 1;
         2: it.cand_score = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         default: it.cand_score = $urandom;
      endcase
      return it;
   endfunction

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] d);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      csr_we    <= 1'b0;
      cfg_write(idx, d);
      n_cfg++;
   endtask

   // sender holds off until every predicted result is back, then a short tail
   task automatic wait_idle();
      while (req_items.size() != 0 || drv_busy || expected_ranks.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // ---------------- driver ----------------

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         drv_busy = 1'b0;
         drv_gap  = 0;
      end else begin
         if (drv_busy && req_ch.valid && req_ch.ready) begin
            if (drv_item.func == FUNC_READ) begin
               store_read();
               n_reads++;
            end else begin
               store_push('{entry_ref: drv_item.cand_ref, entry_score: drv_item.cand_score});
            end
            n_sent++;
            drv_busy = 1'b0;
            drv_gap  = calm ? 0 : $urandom_range(0, 5);
         end
         if (!drv_busy) begin
            if (drv_gap > 0) begin
               drv_gap--;
            end else if (req_items.size() != 0) begin
               drv_item = req_items.pop_front();
               drv_busy = 1'b1;
            end
         end
         req_ch.valid      <= drv_busy;
         req_ch.func       <= drv_item.func;
         req_ch.cand_ref   <= drv_item.cand_ref;
         req_ch.cand_score <= drv_item.cand_score;
      end
   end

   // ---------------- monitor ----------------

   always @(posedge clock) begin
      ranked_t want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         sink_wait = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            n_checked++;
            if (expected_ranks.size() == 0) begin
               n_bad++;
               $error("result transaction with nothing expected: ref %h score %0d",
                      rsp_ch.out_ref, rsp_ch.out_score);
            end else begin
               want = expected_ranks.pop_front();
               if (rsp_ch.out_ref !== want.out_ref) begin
                  n_bad++;
                  $error("out_ref: expected %h, got %h", want.out_ref, rsp_ch.out_ref);
               end
               if (rsp_ch.out_score !== want.out_score) begin
                  n_bad++;
                  $error("out_score: expected %0d, got %0d", want.out_score,
                         rsp_ch.out_score);
               end
               if (rsp_ch.out_rank !== want.out_rank) begin
                  n_bad++;
                  $error("out_rank: expected %0d, got %0d", want.out_rank, rsp_ch.out_rank);
               end
               if (rsp_ch.out_last !== want.out_last) begin
                  n_bad++;
                  $error("out_last: expected %b, got %b", want.out_last, rsp_ch.out_last);
               end
               if (rsp_ch.out_empty !== want.out_empty) begin
                  n_bad++;
                  $error("out_empty: expected %b, got %b", want.out_empty,
                         rsp_ch.out_empty);
               end
            end
            sink_wait = calm ? 0 : $urandom_range(0, 5);
         end else if (sink_wait > 0) begin
            sink_wait--;
         end
         rsp_ch.ready <= (sink_wait == 0);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still expected", cycles,
                  expected_ranks.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------- sequence ----------------

   initial begin
      logic [TOTAL_W-1:0] keeps  [7];
      logic [CSR_W-1:0]   floors [7];
      int p, i;

      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_KEEP_COUNT;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.func = FUNC_PUSH;
      req_ch.cand_ref = '0;
      req_ch.cand_score = '0;
      rsp_ch.ready = 1'b0;
      drv_item = '0;
      drv_busy = 1'b0;
      calm = 1'b0;
      cycles = 0;
      n_sent = 0; n_reads = 0; n_checked = 0; n_bad = 0; n_cfg = 0;
      kept_n = 0;
      keep_cfg = KEEP_COUNT_RESET;
      floor_cfg = SCORE_FLOOR_RESET;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset settings: empty read, extremes, ties on score
      queue_item(FUNC_READ, '1, 32'hFFFF_FFFF);
      queue_item(FUNC_PUSH, 64'h0, 32'h7FFF_FFFF);
      queue_item(FUNC_PUSH, '1, 32'h8000_0000);   // equal to the score floor, kept
      queue_item(FUNC_PUSH, 64'd5, 32'd100);
      queue_item(FUNC_PUSH, 64'd3, 32'd100);
      queue_item(FUNC_PUSH, 64'd7, 32'd100);
      queue_item(FUNC_READ, 64'h0, 32'h0);
      wait_idle();

      // lowering keep_count trims to the best three
      csr_write(CSR_KEEP_COUNT, 32'd3);
      csr_write(CSR_SCORE_FLOOR, 32'd50);
      queue_item(FUNC_READ, 64'h0, 32'h0);
      queue_item(FUNC_PUSH, 64'd5, 32'd100);      // ties the worst entry: dropped
      queue_item(FUNC_PUSH, 64'd9, 32'd49);       // below the floor
      queue_item(FUNC_PUSH, 64'd4, 32'd100);      // beats the worst entry
      queue_item(FUNC_PUSH, 64'd1, 32'd50);
      queue_item(FUNC_READ, 64'h0, 32'h0);
      wait_idle();

      // zero keep_count behaves as one, floor at its maximum
      csr_write(CSR_KEEP_COUNT, 32'd0);
      csr_write(CSR_SCORE_FLOOR, 32'h7FFF_FFFF);
      queue_item(FUNC_PUSH, 64'd0, 32'h7FFF_FFFF);
      queue_item(FUNC_PUSH, 64'd1, 32'h7FFF_FFFE);
      queue_item(FUNC_PUSH, 64'd2, 32'h7FFF_FFFF);
      queue_item(FUNC_READ, 64'h0, 32'h0);
      wait_idle();

      keeps  = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd5, 5'd17, 5'($urandom_range(1, 16))};
      floors = '{32'h8000_0000, 32'h0, 32'h7FFF_FFFF, $urandom, 32'hFFFF_0000,
                 32'h8000_0000, $urandom};
      for (p = 0; p < 7; p++) begin
         csr_write(CSR_KEEP_COUNT, CSR_W'(keeps[p]));
         csr_write(CSR_SCORE_FLOOR, floors[p]);
         calm = (p == 2 || p == 5);
         for (i = 0; i < 22; i++) req_items.push_back(rand_item());
         queue_item(FUNC_READ, {$urandom, $urandom}, $urandom);
         wait_idle();
      end
      calm = 1'b0;

      $display("Ran %0d transactions (%0d reads) over %0d register writes in %0d cycles.",
               n_sent, n_reads, n_cfg, cycles);
      $display("Compared %0d ranked results, %0d field mismatches.", n_checked, n_bad);
      if (n_bad == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
